/* design/mrwt_pkg.sv */
package mrwt_pkg;

    localparam int NUM_WIDTH_DEF = 32;
    localparam int FIELD_WIDTH   = 32;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture n, a; start a mod n
        logic red_step;  // one restoring step of a mod n
        logic dec_step;  // shift one factor of two out of d
        logic mul_init;  // start a modular product
        logic mul_step;  // one double-and-add step
        logic sel_sq;    // product is x*x (else r*b or b*b)
        logic sel_rb;    // product is r*b
        logic wr_r;      // write product to r
        logic wr_b;      // write product to b
        logic wr_x;      // write product to x
        logic exp_shift; // shift exponent right
        logic x_from_r;  // x takes r
        logic cnt_dec;   // count one squaring
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic n_even;
        logic d_even;    // d nonzero and even
        logic e_zero;
        logic e_lsb;
        logic step_last; // last step of a product or reduction
        logic x_one;
        logic x_n1;
        logic cnt_zero;  // no squarings left
    } stat_t;

endpackage

/* design/miller_rabin_witness_test.sv */
// Miller-Rabin witness test. Accepts an odd candidate n and a base a and
// returns is_witness (1: a proves n composite). An even candidate returns
// at once with even_error and is_witness set. Each item first reduces the
// base mod n, then shifts one factor of two out of n-1 per step, then per
// exponent bit squares the base and, when the bit is set, first multiplies
// it into the result, and then runs the closing squarings, all on the
// single shared double-and-add multiplier. One item is in work at a time.
module miller_rabin_witness_test #(
    parameter int NUM_WIDTH = mrwt_pkg::NUM_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] candidate,
    input  logic [31:0] base,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        is_witness,
    output logic        even_error
);
    mrwt_pkg::cmd_t  cmd;
    mrwt_pkg::stat_t stat;

    mrwt_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
        .is_witness, .even_error, .stat, .cmd
    );

    mrwt_datapath #(.NUM_WIDTH(NUM_WIDTH)) u_dp (
        .clk, .rst_n, .candidate, .base, .cmd, .stat
    );

`ifndef SYNTHESIS
    // An even-candidate result always claims a witness
    a_even: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && even_error |-> is_witness)
        else $error("even result without witness");
    // No new input while a result waits
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready with result pending");
`endif
endmodule

/* design/mrwt_datapath.sv */
module mrwt_datapath #(
    parameter int NUM_WIDTH = mrwt_pkg::NUM_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [31:0]          candidate,
    input  logic [31:0]          base,
    input  mrwt_pkg::cmd_t       cmd,
    output mrwt_pkg::stat_t      stat
);
    localparam int CW = $clog2(NUM_WIDTH + 1);

    logic [NUM_WIDTH-1:0] n_reg, n1_reg, d_reg, e_reg, r_reg, b_reg, x_reg, acc_reg, y_reg;
    logic [NUM_WIDTH-1:0] n_next, n1_next, d_next, e_next, r_next, b_next, x_next;
    logic [NUM_WIDTH-1:0] acc_next, y_next;
    logic [CW-1:0]        bit_reg, bit_next, cnt_reg, cnt_next;
    logic [NUM_WIDTH-1:0] mx, my, dbl, addv, in_n, in_a;
    logic [NUM_WIDTH:0]   wide, rem;

    assign in_n = NUM_WIDTH'(candidate);
    assign in_a = NUM_WIDTH'(base);

    // Modular add of p and q mod m; used to double acc, then to add mx when the y bit is set
    function automatic logic [NUM_WIDTH-1:0] addm(input logic [NUM_WIDTH-1:0] p,
                                                  input logic [NUM_WIDTH-1:0] q,
                                                  input logic [NUM_WIDTH-1:0] m);
        logic [NUM_WIDTH:0] t;
        begin
            t = {1'b0, p} + {1'b0, q};
            if (t >= {1'b0, m})
                t = t - {1'b0, m};
            addm = t[NUM_WIDTH-1:0];
        end
    endfunction

    always_comb
    begin
        mx = cmd.sel_sq ? x_reg : b_reg;
        my = cmd.sel_sq ? x_reg : (cmd.sel_rb ? r_reg : b_reg);
        dbl  = addm(acc_reg, acc_reg, n_reg);
        addv = y_reg[NUM_WIDTH-1] ? addm(dbl, mx, n_reg) : dbl;
        // restoring step of a mod n: shift in one bit of a
        wide = {acc_reg, y_reg[NUM_WIDTH-1]};
        rem  = (wide >= {1'b0, n_reg}) ? wide - {1'b0, n_reg} : wide;
    end

    always_comb
    begin
        n_next = n_reg; n1_next = n1_reg; d_next = d_reg; e_next = e_reg;
        r_next = r_reg; b_next = b_reg; x_next = x_reg; acc_next = acc_reg;
        y_next = y_reg; bit_next = bit_reg; cnt_next = cnt_reg;
        if (cmd.load)
        begin
            n_next   = in_n;
            n1_next  = in_n - NUM_WIDTH'(1);
            d_next   = in_n - NUM_WIDTH'(1);
            acc_next = '0;
            y_next   = in_a;
            bit_next = CW'(NUM_WIDTH - 1);
            cnt_next = '0;
            r_next   = (in_n == NUM_WIDTH'(1)) ? '0 : NUM_WIDTH'(1);
        end
        if (cmd.red_step)
        begin
            acc_next = rem[NUM_WIDTH-1:0];
            y_next   = {y_reg[NUM_WIDTH-2:0], 1'b0};
            bit_next = bit_reg - CW'(1);
            if (stat.step_last)
            begin
                b_next = rem[NUM_WIDTH-1:0];
                e_next = d_reg;
            end
        end
        if (cmd.dec_step)
        begin
            d_next   = d_reg >> 1;
            e_next   = d_reg >> 1;
            cnt_next = cnt_reg + CW'(1);
        end
        if (cmd.mul_init)
        begin
            acc_next = '0;
            y_next   = my;
            bit_next = CW'(NUM_WIDTH - 1);
        end
        if (cmd.mul_step)
        begin
            acc_next = addv;
            y_next   = {y_reg[NUM_WIDTH-2:0], 1'b0};
            bit_next = bit_reg - CW'(1);
            if (stat.step_last)
            begin
                if (cmd.wr_r) r_next = addv;
                if (cmd.wr_b) b_next = addv;
                if (cmd.wr_x) x_next = addv;
            end
        end
        if (cmd.exp_shift) e_next = e_reg >> 1;
        if (cmd.x_from_r)
        begin
            x_next   = r_reg;
            cnt_next = (cnt_reg == '0) ? '0 : cnt_reg - CW'(1);
        end
        if (cmd.cnt_dec) cnt_next = cnt_reg - CW'(1);
    end

    // Hold payload; no reset needed except counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            bit_reg <= bit_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next; n1_reg <= n1_next; d_reg <= d_next; e_reg <= e_next;
        r_reg <= r_next; b_reg <= b_next; x_reg <= x_next;
        acc_reg <= acc_next; y_reg <= y_next;
    end

    always_comb
    begin
        stat.n_even    = ~in_n[0];
        stat.d_even    = (d_reg != '0) && !d_reg[0];
        stat.e_zero    = (e_reg == '0);
        stat.e_lsb     = e_reg[0];
        stat.step_last = (bit_reg == '0);
        stat.x_one     = (x_reg == NUM_WIDTH'(1));
        stat.x_n1      = (x_reg == n1_reg);
        stat.cnt_zero  = (cnt_reg == '0);
    end
endmodule

/* design/mrwt_ctrl.sv */
module mrwt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            is_witness,
    output logic            even_error,
    input  mrwt_pkg::stat_t stat,
    output mrwt_pkg::cmd_t  cmd
);
    localparam logic [3:0] S_IDLE = 4'd0, S_RED = 4'd1, S_DEC = 4'd2, S_EXP = 4'd3,
                           S_MRB = 4'd4, S_MBB = 4'd5, S_CHK = 4'd6, S_SQ = 4'd7,
                           S_SQC = 4'd8, S_DONE = 4'd9, S_MRBI = 4'd10,
                           S_MBBI = 4'd11, S_SQI = 4'd12;

    logic [3:0] state_reg, state_next;
    logic       wit_reg, wit_next, err_reg, err_next, ov_reg, ov_next;

    assign in_ready   = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid  = ov_reg;
    assign is_witness = wit_reg;
    assign even_error = err_reg;

    // Sequence input, reduction, factor-of-two removal, exponentiation, check and squarings
    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        wit_next = wit_reg; err_next = err_reg;
        ov_next = ov_reg && !out_ready;
        case (state_reg)
            S_IDLE:
                if (in_valid && in_ready)
                begin
                    if (stat.n_even)
                    begin
                        wit_next = 1'b1; err_next = 1'b1; ov_next = 1'b1;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                        state_next = S_RED;
                    end
                end
            S_RED:
            begin
                cmd.red_step = 1'b1;
                if (stat.step_last) state_next = S_DEC;
            end
            S_DEC:
                if (stat.d_even) cmd.dec_step = 1'b1;
                else state_next = S_EXP;
            S_EXP:
                if (stat.e_zero)
                begin
                    cmd.x_from_r = 1'b1;
                    state_next = S_CHK;
                end
                else if (stat.e_lsb)
                begin
                    cmd.mul_init = 1'b1; cmd.sel_rb = 1'b1;
                    state_next = S_MRB;
                end
                else
                begin
                    cmd.mul_init = 1'b1;
                    state_next = S_MBB;
                end
            S_MRB:
            begin
                cmd.mul_step = 1'b1; cmd.wr_r = 1'b1;
                if (stat.step_last)
                begin
                    state_next = S_MBBI;
                end
            end
            S_MBBI:
            begin
                cmd.mul_init = 1'b1;
                state_next = S_MBB;
            end
            S_MBB:
            begin
                cmd.mul_step = 1'b1; cmd.wr_b = 1'b1;
                if (stat.step_last)
                begin
                    cmd.exp_shift = 1'b1;
                    state_next = S_EXP;
                end
            end
            S_CHK:
                if (stat.x_one || stat.x_n1)
                begin
                    wit_next = 1'b0; err_next = 1'b0; ov_next = 1'b1;
                    state_next = S_IDLE;
                end
                else state_next = S_SQC;
            S_SQC:
                if (stat.cnt_zero)
                begin
                    wit_next = 1'b1; err_next = 1'b0; ov_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.mul_init = 1'b1; cmd.sel_sq = 1'b1; cmd.cnt_dec = 1'b1;
                    state_next = S_SQ;
                end
            S_SQ:
            begin
                cmd.mul_step = 1'b1; cmd.sel_sq = 1'b1; cmd.wr_x = 1'b1;
                if (stat.step_last) state_next = S_SQI;
            end
            S_SQI:
                if (stat.x_n1)
                begin
                    wit_next = 1'b0; err_next = 1'b0; ov_next = 1'b1;
                    state_next = S_IDLE;
                end
                else state_next = S_SQC;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            wit_reg   <= 1'b0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            wit_reg   <= wit_next;
            err_reg   <= err_next;
        end
    end
endmodule

/* test/miller_rabin_witness_test_tb.sv */
`timescale 1ns / 100ps

module miller_rabin_witness_test_tb;

    localparam int CYCLE_LIMIT = 3_000_000;

    // Expected verdicts, oldest first; checks each transfer on the result side
    class verdict_board;
        bit exp_witness[$];
        bit exp_even[$];
        int errors;
        int checked;

        function void note(bit witness, bit even_flag);
            exp_witness.push_back(witness);
            exp_even.push_back(even_flag);
        endfunction

        function void check(bit witness, bit even_flag);
            bit w;
            bit e;
            if (exp_witness.size() == 0)
            begin
                $display("%0t: unexpected result is_witness=%0b even_error=%0b",
                         $time, witness, even_flag);
                errors++;
                return;
            end
            w = exp_witness.pop_front();
            e = exp_even.pop_front();
            checked++;
            if (w !== witness)
            begin
                $display("%0t: is_witness expected %0b actual %0b", $time, w, witness);
                errors++;
            end
            if (e !== even_flag)
            begin
                $display("%0t: even_error expected %0b actual %0b", $time, e, even_flag);
                errors++;
            end
        endfunction

        function int pending();
            return exp_witness.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] candidate;
    logic [31:0] base;
    logic        out_valid;
    logic        out_ready;
    logic        is_witness;
    logic        even_error;

    verdict_board board;
    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;
    int cycles;

    miller_rabin_witness_test u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .candidate  (candidate),
        .base       (base),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .is_witness (is_witness),
        .even_error (even_error)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // (x * y) mod m by double-and-add, all values below m
    function automatic logic [31:0] prod_mod(logic [31:0] x, logic [31:0] y,
                                             logic [31:0] m);
        logic [32:0] acc;
        acc = '0;
        for (int k = 31; k >= 0; k--)
        begin
            acc = acc + acc;
            if (acc >= m)
                acc = acc - m;
            if (y[k])
            begin
                acc = acc + x;
                if (acc >= m)
                    acc = acc - m;
            end
        end
        return acc[31:0];
    endfunction

    // Work out the verdict of the strong probable-prime test for one pair
    function automatic void predict_verdict(logic [31:0] n, logic [31:0] a,
                                            output bit witness, output bit even_flag);
        logic [31:0] n1;
        logic [31:0] d;
        logic [31:0] b;
        logic [31:0] r;
        logic [31:0] x;
        int          s;
        s = 0;
        if (!n[0])
        begin
            witness = 1'b1;
            even_flag = 1'b1;
            return;
        end
        even_flag = 1'b0;
        n1 = n - 1;
        d = n1;
        while (d != 0 && !d[0])
        begin
            d = d >> 1;
            s++;
        end
        b = a % n;
        r = (n == 1) ? 32'd0 : 32'd1;
        while (d != 0)
        begin
            if (d[0])
                r = prod_mod(r, b, n);
            b = prod_mod(b, b, n);
            d = d >> 1;
        end
        x = r;
        witness = 1'b1;
        if (x == 1 || x == n1)
            witness = 1'b0;
        else
            for (int i = 1; i < s; i++)
            begin
                x = prod_mod(x, x, n);
                if (x == n1)
                begin
                    witness = 1'b0;
                    break;
                end
            end
    endfunction

    // Offer one pair, hold it until the transfer, note the expected verdict;
    // valid drops on the next idle cycle or on the drain
    task automatic send_pair(logic [31:0] n, logic [31:0] a);
        bit w;
        bit e;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        candidate <= n;
        base      <= a;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_verdict(n, a, w, e);
        board.note(w, e);
        items_sent++;
        @(negedge clk);
    endtask

    // Random candidate, often small and now and then even; sometimes a prime or a strong pseudoprime
    task automatic send_random_pair();
        logic [31:0] n;
        logic [31:0] a;
        int          pick;
        pick = $urandom_range(99);
        case (1'b1)
            pick < 35: n = $urandom_range(200, 3) | 32'd1;
            pick < 60: n = $urandom() | 32'd1;
            pick < 75:
            begin
                case ($urandom_range(5))
                    0: n = 32'd2047;
                    1: n = 32'd3215031751;
                    2: n = 32'd4294967291;
                    3: n = 32'd2147483647;
                    4: n = 32'd65537;
                    default: n = 32'd25326001;
                endcase
            end
            pick < 85: n = $urandom();
            default: n = ($urandom_range(1 << 20) << $urandom_range(11)) | 32'd1;
        endcase
        if ($urandom_range(3) == 0)
            a = $urandom();
        else
            a = $urandom_range(40, 2);
        send_pair(n, a);
    endtask

    // Drop valid and hold off until every verdict is in
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (2300) @(posedge clk);
        @(negedge clk);
    endtask

    // Result side: random stalls, check every transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check(is_witness, even_error);
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Give up far beyond the slowest correct run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        board         = new();
        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        candidate     = '0;
        base          = '0;
        out_ready     = 1'b0;
        send_idle_pct = 24;
        recv_idle_pct = 68;
        items_sent    = 0;
        cycles        = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, even and tiny candidates, reduced bases, pseudoprimes
        send_pair(32'd0, 32'd5);
        send_pair(32'd2, 32'd1);
        send_pair(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_pair(32'd1, 32'd0);
        send_pair(32'd1, 32'hFFFF_FFFF);
        send_pair(32'd3, 32'd2);
        send_pair(32'd3, 32'd0);
        send_pair(32'd5, 32'd10);
        send_pair(32'd9, 32'd2);
        send_pair(32'd2047, 32'd2);
        send_pair(32'd2047, 32'd3);
        send_pair(32'd561, 32'd2);
        send_pair(32'd97, 32'd96);
        send_pair(32'd97, 32'd97 + 32'd5);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(32'hFFFF_FFFF, 32'd2);
        send_pair(32'd4294967291, 32'hFFFF_FFFE);
        send_pair(32'd4294967291, 32'h5555_5555);
        send_pair(32'h8000_0001, 32'hAAAA_AAAA);
        send_pair(32'd3215031751, 32'd2);

        // Hold off until every verdict is in
        wait_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 68 : 0;
            recv_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 24 : 0;
            repeat (84)
                send_random_pair();
        end

        wait_drained();
        $display("covered %0d candidate/base pairs, %0d verdicts checked, including",
                 items_sent, board.checked);
        $display("even, unit and maximal candidates and known strong pseudoprimes");
        if (board.errors == 0 && board.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
